### hdl/ssq_pkg.sv
// shared types and constants for the sorted sleep-timer queue
package ssq_pkg;

  localparam int TIME_W = 64;
  localparam int TID_W = 6;
  localparam int SLEEP_W = 32;
  localparam int STEP_W = 10;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd10;

  // input operations carried on s_tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // result kinds carried on m_tuser
  localparam logic EV_WOKEN    = 1'b0;
  localparam logic EV_REJECTED = 1'b1;

  // one queue entry as held in the entry memory
  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [TID_W-1:0]  tid;
  } entry_t;

  // shared add and compare unit
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              lt;
  } alu_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLEEP_ADD,
    S_INS_CMP,
    S_INS_PUT,
    S_REJECT,
    S_TICK_ADD,
    S_TICK_CMP,
    S_TICK_FLUSH
  } state_t;

endpackage

### hdl/ssq_ram.sv
// generic simple dual-port memory with registered read
module ssq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/ssq_alu.sv
// shared 64-bit adder and unsigned less-than compare
module ssq_alu import ssq_pkg::*; (
  input  alu_in_t  op_in,
  output alu_out_t res
);

  // wrap-around sum and unsigned compare of the same operands
  always_comb begin
    res.sum = op_in.a + op_in.b;
    res.lt  = (op_in.a < op_in.b);
  end

endmodule

### hdl/sorted_sleep_timer_queue_unit.sv
// top level: sorted sleep-timer queue with its sequencer
// A sleep word (s_tuser = 1) adds now + sleep_ms as a wake time into a queue kept in ascending
// order, ahead of equal times; a zero duration gives no result, and a full queue gives one
// rejected word (m_tuser = 1, m_tlast = 1). A tick word (s_tuser = 0) adds the configured step
// to the millisecond clock and wakes every entry due at the new time, one word each, the final
// one with m_tlast set. Entries sit in one memory used as a ring, one read and one write a cycle,
// and a single 64-bit add/compare unit is stepped over them. s_tready is high only in idle. A
// sleep first forms the wake time, then walks from the tail, comparing each entry with a later
// or equal wake time and moving it up one place, until an earlier entry stops the walk or the
// head entry has been moved, and then writes the new entry; a zero duration returns to idle
// after the add, and a rejected sleep waits while the output is held. A tick advances the clock
// and, on a non-empty queue, checks entries from the head, waking each due one, then drops the
// woken entries; it waits while the output is held. The memory needs no clearing after reset;
// the step register can be written whenever the block is idle.
module sorted_sleep_timer_queue_unit import ssq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  // tick step register
  input  logic              step_wr_en,
  input  logic [STEP_W-1:0] step_wr_data,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // [5:0] task_id, [37:6] sleep_ms, [39:38] zero
  input  logic              s_tuser,   // operation
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [5:0] task_id_out, [7:6] zero
  output logic              m_tuser,   // event_res
  output logic              m_tlast    // last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] OCC_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [STEP_W-1:0]  step;
  logic [TIME_W-1:0]  now_ms, now_ms_next;
  logic [CW-1:0]      occ, occ_next;
  logic [AW-1:0]      head, head_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      idx_inc;
  logic [TIME_W-1:0]  key, key_next;
  logic [TID_W-1:0]   in_tid;
  logic [SLEEP_W-1:0] in_ms;
  logic               pend_valid, pend_valid_next;
  logic [TID_W-1:0]   pend_tid, pend_tid_next;

  logic               out_load, out_free;
  logic [TID_W-1:0]   out_tid_next;
  logic               out_rej_next, out_last_next;
  logic [TID_W-1:0]   out_tid;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  alu_in_t            alu_in;
  alu_out_t           alu_res;

  // logical queue position to memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(hd) + {1'b0, k};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  ssq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ssq_alu u_alu (
    .op_in(alu_in),
    .res  (alu_res)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign idx_inc  = idx + 1'b1;
  assign m_tdata  = {2'b00, out_tid};

  // sequencer: next state, memory and unit control
  always_comb begin
    state_next      = state;
    now_ms_next     = now_ms;
    occ_next        = occ;
    head_next       = head;
    idx_next        = idx;
    key_next        = key;
    pend_valid_next = pend_valid;
    pend_tid_next   = pend_tid;
    out_load        = 1'b0;
    out_tid_next    = pend_tid;
    out_rej_next    = EV_WOKEN;
    out_last_next   = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = phys(head, idx_inc);
    ram_wdata       = ram_rdata;
    ram_raddr       = phys(head, idx);
    alu_in.a        = now_ms;
    alu_in.b        = {{(TIME_W-SLEEP_W){1'b0}}, in_ms};

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == OP_SLEEP) ? S_SLEEP_ADD : S_TICK_ADD;
        end
      end

      // wake time, then start the walk from the tail
      S_SLEEP_ADD: begin
        key_next = alu_res.sum;
        if (in_ms == '0) begin
          state_next = S_IDLE;
        end else if (occ == OCC_FULL) begin
          state_next = S_REJECT;
        end else if (occ == '0) begin
          idx_next   = '0;
          state_next = S_INS_PUT;
        end else begin
          idx_next   = occ - 1'b1;
          ram_raddr  = phys(head, occ - 1'b1);
          state_next = S_INS_CMP;
        end
      end

      // move entries with wake >= key up one place
      S_INS_CMP: begin
        alu_in.a = ram_rdata.wake;
        alu_in.b = key;
        if (alu_res.lt) begin
          idx_next   = idx_inc;
          state_next = S_INS_PUT;
        end else begin
          ram_we = 1'b1;
          if (idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            idx_next  = idx - 1'b1;
            ram_raddr = phys(head, idx - 1'b1);
          end
        end
      end

      S_INS_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = phys(head, idx);
        ram_wdata.wake = key;
        ram_wdata.tid  = in_tid;
        occ_next       = occ + 1'b1;
        state_next     = S_IDLE;
      end

      S_REJECT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_tid_next  = in_tid;
          out_rej_next  = EV_REJECTED;
          out_last_next = 1'b1;
          state_next    = S_IDLE;
        end
      end

      // advance the clock and read the head
      S_TICK_ADD: begin
        alu_in.b        = {{(TIME_W-STEP_W){1'b0}}, step};
        now_ms_next     = alu_res.sum;
        idx_next        = '0;
        pend_valid_next = 1'b0;
        ram_raddr       = head;
        state_next      = (occ == '0) ? S_IDLE : S_TICK_CMP;
      end

      // one entry checked per cycle unless the output is held, the previous due one held back for its last flag
      S_TICK_CMP: begin
        alu_in.a = now_ms;
        alu_in.b = ram_rdata.wake;
        if (alu_res.lt) begin
          state_next = S_TICK_FLUSH;
        end else if (!pend_valid || out_free) begin
          out_load        = pend_valid;
          pend_valid_next = 1'b1;
          pend_tid_next   = ram_rdata.tid;
          idx_next        = idx_inc;
          if (idx_inc < occ) begin
            ram_raddr = phys(head, idx_inc);
          end else begin
            state_next = S_TICK_FLUSH;
          end
        end
      end

      // final woken word, then drop the woken entries
      S_TICK_FLUSH: begin
        if (!pend_valid || out_free) begin
          out_load        = pend_valid;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          head_next       = phys(head, idx);
          occ_next        = occ - idx;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms     <= '0;
      occ        <= '0;
      head       <= '0;
      pend_valid <= 1'b0;
      step       <= TICK_STEP_RESET;
    end else begin
      now_ms     <= now_ms_next;
      occ        <= occ_next;
      head       <= head_next;
      pend_valid <= pend_valid_next;
      if (step_wr_en) begin
        step <= step_wr_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    key      <= key_next;
    pend_tid <= pend_tid_next;
    if (s_tvalid && s_tready) begin
      in_tid <= s_tdata[5:0];
      in_ms  <= s_tdata[37:6];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tid <= out_tid_next;
      m_tuser <= out_rej_next;
      m_tlast <= out_last_next;
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= OCC_FULL)
    else $error("queue occupancy beyond depth");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("rejected word without last");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !pend_valid)
    else $error("woken word left pending at accept");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_PUT) |=> (occ == $past(occ) + 1'b1))
    else $error("insert did not grow the queue");

endmodule
